/* hdl/rgbd_pkg.sv */
// Package for the RGB-to-mono ordered dither block.
// Holds tile and queue sizes, luma weights, register indexes and shared types.
// No dependencies.
package rgbd_pkg;

    // Dither tile edge; the phases count 0 .. TILE_SIZE-1 (range 2 to 8).
    localparam int TILE_SIZE = 3;
    localparam int PHASE_W   = $clog2(TILE_SIZE);
    localparam int PHASE_MAX_W = 3;

    localparam int PIX_W = 8;
    localparam int THR_W = 8;
    localparam int ROW_W = 3 * THR_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THR_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_ROW2 = 2'd2;

    localparam logic [ROW_W-1:0] THR_ROW0_RST = 24'h39FF1C;
    localparam logic [ROW_W-1:0] THR_ROW1_RST = 24'hE3718E;
    localparam logic [ROW_W-1:0] THR_ROW2_RST = 24'h55C6AA;

    // Luma weights in Q0.16; they sum to exactly 65536.
    localparam int PROD_W = 24;
    localparam logic [PROD_W-1:0] WEIGHT_R = 24'd19595;
    localparam logic [PROD_W-1:0] WEIGHT_G = 24'd38470;
    localparam logic [PROD_W-1:0] WEIGHT_B = 24'd7471;

    localparam logic [PIX_W-1:0] LEVEL_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] LEVEL_BLACK = 8'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified pixel on its way from the front end to the datapath.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [THR_W-1:0] threshold;
        logic             line_end;
    } t_item;

    typedef logic [1:0] t_mod3;

    // Phase modulo three; the phase never exceeds seven.
    function automatic t_mod3 phase_mod3(input logic [PHASE_MAX_W-1:0] p);
        t_mod3 m;
        case (p)
            3'd0, 3'd3, 3'd6: m = 2'd0;
            3'd1, 3'd4, 3'd7: m = 2'd1;
            default:          m = 2'd2;
        endcase
        return m;
    endfunction

endpackage

/* hdl/rgbd_pixel_if.sv */
// Input channel of the dither block: one RGB pixel per beat.
// Depends on rgbd_pkg.
interface rgbd_pixel_if
    import rgbd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
    logic             line_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, output line_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, input line_end, output ready);
endinterface

/* hdl/rgbd_mono_if.sv */
// Output channel of the dither block: one dithered level per beat.
// Depends on rgbd_pkg.
interface rgbd_mono_if
    import rgbd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mono_level;
    logic             line_end_out;

    modport source (output valid, output mono_level, output line_end_out, input ready);
    modport sink   (input valid, input mono_level, input line_end_out, output ready);
endinterface

/* hdl/rgbd_front.sv */
// Front end: threshold registers, tile phase counters and threshold lookup.
// Depends on rgbd_pkg.
module rgbd_front
    import rgbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_red,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic                 i_frame_start,
    input  logic                 i_line_end,
    output logic                 o_push,
    input  logic                 i_space,
    output t_item                o_item
);

    logic [ROW_W-1:0]   r_thr_row0, r_thr_row1, r_thr_row2;
    logic [PHASE_W-1:0] r_col, r_row, n_col, n_row;
    logic [PHASE_W-1:0] cur_col, cur_row;
    logic [ROW_W-1:0]   sel_row;
    logic [THR_W-1:0]   sel_thr;
    logic               accept;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign o_push  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_row0 <= THR_ROW0_RST;
            r_thr_row1 <= THR_ROW1_RST;
            r_thr_row2 <= THR_ROW2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THR_ROW0: r_thr_row0 <= i_cfg_data;
                REG_THR_ROW1: r_thr_row1 <= i_cfg_data;
                REG_THR_ROW2: r_thr_row2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A frame start clears both phases before this pixel uses them.
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;

    always_comb begin
        unique case (phase_mod3(PHASE_MAX_W'(cur_row)))
            2'd1:    sel_row = r_thr_row1;
            2'd2:    sel_row = r_thr_row2;
            default: sel_row = r_thr_row0;
        endcase
        unique case (phase_mod3(PHASE_MAX_W'(cur_col)))
            2'd1:    sel_thr = sel_row[2*THR_W-1:THR_W];
            2'd2:    sel_thr = sel_row[3*THR_W-1:2*THR_W];
            default: sel_thr = sel_row[THR_W-1:0];
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_line_end) begin
                n_col = '0;
                n_row = (cur_row == PHASE_W'(TILE_SIZE - 1)) ? '0 : cur_row + 1'b1;
            end else begin
                n_col = (cur_col == PHASE_W'(TILE_SIZE - 1)) ? '0 : cur_col + 1'b1;
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_item.red       = i_red;
    assign o_item.green     = i_green;
    assign o_item.blue      = i_blue;
    assign o_item.threshold = sel_thr;
    assign o_item.line_end  = i_line_end;

endmodule

/* hdl/rgbd_queue.sv */
// Short first-word-fall-through queue between the front end and the datapath.
// Depends on rgbd_pkg.
module rgbd_queue
    import rgbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_space,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  do_push, do_pop;

    assign o_space = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hdl/rgbd_back.sv */
// Datapath: weighted products, then luma sum, threshold compare and output register.
// Depends on rgbd_pkg.
module rgbd_back
    import rgbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  t_item            i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_mono_level,
    output logic             o_line_end_out
);

    logic              r_a_valid;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [THR_W-1:0]  r_a_thr;
    logic              r_a_line_end;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_level;
    logic              r_out_line_end;
    logic              out_ready, a_ready, a_load;
    logic [PROD_W-1:0] luma_sum;
    logic [PIX_W-1:0]  luma;

    assign out_ready = !r_out_valid || i_ready;
    assign a_ready   = !r_a_valid || out_ready;
    assign a_load    = i_valid && a_ready;
    assign o_pop     = a_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_prod_r     <= PROD_W'(i_item.red) * WEIGHT_R;
            r_prod_g     <= PROD_W'(i_item.green) * WEIGHT_G;
            r_prod_b     <= PROD_W'(i_item.blue) * WEIGHT_B;
            r_a_thr      <= i_item.threshold;
            r_a_line_end <= i_item.line_end;
        end
    end

    // The weights sum to 65536, so the sum never leaves 24 bits.
    assign luma_sum = r_prod_r + r_prod_g + r_prod_b;
    assign luma     = luma_sum[PROD_W-1:PROD_W-PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_a_valid) begin
            r_out_level    <= (luma > r_a_thr) ? LEVEL_WHITE : LEVEL_BLACK;
            r_out_line_end <= r_a_line_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mono_level   = r_out_level;
    assign o_line_end_out = r_out_line_end;

endmodule

/* hdl/rgb_gray_ordered_dither_unit.sv */
// Ordered dither of an RGB pixel stream to black and white.
// Channels: i_pix takes one RGB pixel per beat in raster order, with a
// frame_start flag on the first pixel of a frame and line_end on the last
// pixel of each row. o_mono gives one beat per pixel, in order: mono_level is
// 255 when the luma (0.299/0.587/0.114 in Q0.16, truncated to 8 bits) is
// strictly above the threshold picked by the tile phases, else 0, and
// line_end_out copies line_end.
// Thresholds sit in three 24-bit registers, one per row phase, column phase 0
// in the low byte; write them through i_cfg_* while the block is idle.
// Throughput is one pixel per clock while o_mono is not stalled. An
// accepted pixel passes through the queue, then the product registers,
// and then it is held in the output register. A four-beat queue behind the
// front end keeps i_pix.ready high for up to six outstanding pixels while
// o_mono is stalled; after that, ready drops until the receiver takes a beat.
// Reset (synchronous, active low) empties the queue and pipeline, clears both
// phases and loads the default 3x3 threshold matrix.
// Depends on rgbd_pkg, rgbd_pixel_if, rgbd_mono_if, rgbd_front, rgbd_queue,
// rgbd_back.
module rgb_gray_ordered_dither_unit
    import rgbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data,
    rgbd_pixel_if.sink           i_pix,
    rgbd_mono_if.source          o_mono
);

    logic  push, space, q_valid, pop;
    t_item push_item, pop_item;

    rgbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_red         (i_pix.red),
        .i_green       (i_pix.green),
        .i_blue        (i_pix.blue),
        .i_frame_start (i_pix.frame_start),
        .i_line_end    (i_pix.line_end),
        .o_push        (push),
        .i_space       (space),
        .o_item        (push_item)
    );

    rgbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .i_item  (push_item),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (pop_item)
    );

    rgbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_pop          (pop),
        .i_item         (pop_item),
        .o_valid        (o_mono.valid),
        .i_ready        (o_mono.ready),
        .o_mono_level   (o_mono.mono_level),
        .o_line_end_out (o_mono.line_end_out)
    );

endmodule

/* hdl/rgbd_checker.sv */
// Port-level checks for the dither block, attached to the top level by bind.
// Depends on rgbd_pkg and rgb_gray_ordered_dither_unit.
module rgbd_checker
    import rgbd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_out_level,
    input logic             i_out_line_end
);

    // Beats accepted but not yet delivered; the block holds at most six.
    logic [3:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(i_in_valid && i_in_ready)
                                   - 4'(i_out_valid && i_out_ready);
        end
    end

    a_level_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_level == LEVEL_WHITE || i_out_level == LEVEL_BLACK))
        else $error("mono level is neither black nor white");

    a_no_orphan_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 4'd0))
        else $error("output beat without an accepted input beat");

    a_bounded_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd6)
        else $error("more beats held than the queue and pipeline can store");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_level)
                                        && $stable(i_out_line_end))
        else $error("stalled output beat changed or vanished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_gray_ordered_dither_unit rgbd_checker u_rgbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_pix.valid),
    .i_in_ready     (i_pix.ready),
    .i_out_valid    (o_mono.valid),
    .i_out_ready    (o_mono.ready),
    .i_out_level    (o_mono.mono_level),
    .i_out_line_end (o_mono.line_end_out)
);
